FILE: rtl/core/wwdt_pkg.sv
package wwdt_pkg;

  // item kinds
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // register offsets
  localparam logic OFFS_CONTROL = 1'b0;
  localparam logic OFFS_STATUS  = 1'b1;

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_CLOSED = 2'd1;
  localparam logic [1:0] PH_OPEN   = 2'd2;

  localparam int CNT_W = 18;

  localparam logic [7:0] WINDOW_MASK = 8'hf0;
  localparam logic [7:0] PERIOD_MASK = 8'h0f;
  localparam logic [7:0] LOCK_MASK   = 8'h80;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [1:0] phase;
    cnt_t       count;
  } seq_t;

  // 1 << (v + 2) ticks
  function automatic cnt_t ticks_of(input logic [3:0] v);
    logic [4:0] sh;
    sh = {1'b0, v} + 5'd2;
    return cnt_t'(1) << sh;
  endfunction

  // phase and count that a (re)start from a control value gives
  function automatic seq_t start_seq(input logic [7:0] ctrl);
    seq_t s;
    if ((ctrl & WINDOW_MASK) != 8'h00) begin
      s.phase = PH_CLOSED;
      s.count = ticks_of(ctrl[7:4]);
    end else if ((ctrl & PERIOD_MASK) != 8'h00) begin
      s.phase = PH_OPEN;
      s.count = ticks_of(ctrl[3:0]);
    end else begin
      s.phase = PH_IDLE;
      s.count = '0;
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/wwdt_in_if.sv
interface wwdt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       reg_offset;
  logic [7:0] write_data;
  logic       protect_open;

  modport source (output valid, output mode, output reg_offset, output write_data,
                  output protect_open, input ready);
  modport sink (input valid, input mode, input reg_offset, input write_data,
                input protect_open, output ready);
endinterface

FILE: rtl/core/wwdt_out_if.sv
interface wwdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       system_reset;

  modport source (output valid, output read_data, output system_reset, input ready);
  modport sink (input valid, input read_data, input system_reset, output ready);
endinterface

FILE: rtl/core/windowed_watchdog_timer_top.sv
// Windowed watchdog with a control and a status byte register. Every input word
// (tick, register read, register write or watchdog clear) gives exactly one result
// word. A new word is taken every cycle while the result side does not stall; an
// accepted word sits in the input register and the one-step counter and register
// update loads the result register from it, and both stages hold while the result
// side stalls.
module windowed_watchdog_timer_top (
  input logic       clk,
  input logic       rst_n,
  wwdt_in_if.sink   in_chan,
  wwdt_out_if.source out_chan
);

  // input register
  logic       s1_valid_r;
  logic [1:0] s1_mode_r;
  logic       s1_offs_r;
  logic [7:0] s1_data_r;
  logic       s1_prot_r;

  // watchdog state
  logic [7:0]        control_r, control_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [1:0]        phase_r, phase_nxt;
  wwdt_pkg::cnt_t    count_r, count_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_rd_r, rd_nxt;
  logic       out_rst_r, rst_nxt;

  logic          advance;
  wwdt_pkg::seq_t seq;

  assign advance      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || advance;

  always_comb begin
    control_nxt = control_r;
    status_nxt  = status_r;
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    rd_nxt      = 8'h00;
    rst_nxt     = 1'b0;
    seq         = wwdt_pkg::start_seq(control_r);
    case (s1_mode_r)
      wwdt_pkg::MODE_TICK: begin
        if (phase_r == wwdt_pkg::PH_CLOSED || phase_r == wwdt_pkg::PH_OPEN) begin
          if (count_r > wwdt_pkg::cnt_t'(1)) begin
            count_nxt = count_r - wwdt_pkg::cnt_t'(1);
          end else if (phase_r == wwdt_pkg::PH_CLOSED) begin
            // window opens, timeout count starts
            phase_nxt = wwdt_pkg::PH_OPEN;
            count_nxt = wwdt_pkg::ticks_of(control_r[3:0]);
          end else begin
            rst_nxt   = 1'b1;
            phase_nxt = wwdt_pkg::PH_IDLE;
            count_nxt = '0;
          end
        end
      end
      wwdt_pkg::MODE_READ: begin
        rd_nxt = (s1_offs_r == wwdt_pkg::OFFS_STATUS) ? status_r : control_r;
      end
      wwdt_pkg::MODE_WRITE: begin
        if (s1_offs_r == wwdt_pkg::OFFS_STATUS) begin
          status_nxt = s1_data_r & wwdt_pkg::LOCK_MASK;
        end else if (s1_prot_r) begin
          control_nxt = s1_data_r;
          // a zero write leaves a running count alone
          if (s1_data_r != 8'h00) begin
            seq       = wwdt_pkg::start_seq(s1_data_r);
            phase_nxt = seq.phase;
            count_nxt = seq.count;
          end
        end
      end
      default: begin
        if (phase_r == wwdt_pkg::PH_CLOSED) begin
          // clear inside the closed window
          rst_nxt   = 1'b1;
          phase_nxt = wwdt_pkg::PH_IDLE;
          count_nxt = '0;
        end else begin
          phase_nxt = seq.phase;
          count_nxt = seq.count;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      control_r   <= 8'h00;
      status_r    <= 8'h00;
      phase_r     <= wwdt_pkg::PH_IDLE;
      count_r     <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          control_r <= control_nxt;
          status_r  <= status_nxt;
          phase_r   <= phase_nxt;
          count_r   <= count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_mode_r <= in_chan.mode;
      s1_offs_r <= in_chan.reg_offset;
      s1_data_r <= in_chan.write_data;
      s1_prot_r <= in_chan.protect_open;
    end
    if (advance && s1_valid_r) begin
      out_rd_r  <= rd_nxt;
      out_rst_r <= rst_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.read_data    = out_rd_r;
  assign out_chan.system_reset = out_rst_r;

endmodule
